// ===== rtl/tlts_pkg.sv =====
// Package for the two-level thread scheduler: operation codes, slot status
// codes, result status codes and the controller/datapath command types.
package tlts_pkg;

   localparam int OpW = 3;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_TICK   = 3'd1,
      OP_BLOCK  = 3'd2,
      OP_NETRDY = 3'd3,
      OP_EXIT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_WAITING = 2'd3
   } slot_st_type;

   typedef enum logic [1:0] {
      RS_OK      = 2'd0,
      RS_NOFREE  = 2'd1,
      RS_NOWAIT  = 2'd2,
      RS_IDLE    = 2'd3
   } rsp_st_type;

   // Command from controller to datapath, one phase of an event per cycle.
   typedef struct packed {
      logic start;      // latch op/priority, snapshot previous running context
      logic execute;    // apply the event and the first requeue
      logic dispatch;   // pick the next thread from the ready queues if requested
      logic finish;     // load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic need_dispatch;
   } dp_status_type;

endpackage

// ===== rtl/tlts_datapath.sv =====
// Datapath of the thread scheduler: slot tables, three circular queues,
// running context and the result register. Depends on tlts_pkg.
module tlts_datapath
   import tlts_pkg::*;
#(
   parameter int THREAD_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           quantum_len,
   input  logic [OpW-1:0]       op_code,
   input  logic                 prio_in,
   input  dp_cmd_type           cmd,
   output dp_status_type        stat,
   output logic [3:0]           running_thread,
   output logic                 running_idle,
   output logic                 switched,
   output logic                 preempted,
   output logic [3:0]           new_thread,
   output logic [1:0]           status
);
   localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int CW = $clog2(THREAD_SLOTS + 1);
   // queue storage rounded up to a power of two so the pointers wrap on their own
   localparam int QD = 1 << SW;
   localparam logic [CW-1:0] FULL = CW'(THREAD_SLOTS);

   logic [1:0]    slot_st_ff   [THREAD_SLOTS];
   logic          slot_prio_ff [THREAD_SLOTS];
   logic [7:0]    slot_tick_ff [THREAD_SLOTS];
   logic [SW-1:0] q_mem_ff     [3][QD];
   logic [SW-1:0] head_ff [3];
   logic [CW-1:0] cnt_ff  [3];
   logic [SW-1:0] cur_ff, prev_cur_ff;
   logic          idle_ff, prev_idle_ff;
   logic [OpW-1:0] op_ff;
   logic          prio_ff;
   logic          disp_ff, pre_ff;
   logic [SW-1:0] newt_ff;
   logic [1:0]    stat_ff;

   // free-slot search, registered at start
   logic [SW-1:0] free_idx;
   logic          free_found;
   logic [SW-1:0] free_ff;
   logic          free_ok_ff;

   always_comb begin
      free_idx = '0;
      free_found = 1'b0;
      for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
         if (slot_st_ff[i] == ST_FREE) begin
            free_idx = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign stat.need_dispatch = disp_ff;

   function automatic logic [SW-1:0] tail_of(logic [SW-1:0] h, logic [CW-1:0] c);
      return h + c[SW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      logic [1:0] q;
      logic [SW-1:0] v;
      logic [7:0] t;
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_st_ff[i]   <= (i == 0) ? ST_RUNNING : ST_FREE;
            slot_prio_ff[i] <= 1'b0;
         end
         slot_tick_ff[0] <= 8'd10;
         for (int k = 0; k < 3; k++) begin
            head_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
         cur_ff <= '0;
         idle_ff <= 1'b0;
         disp_ff <= 1'b0;
         pre_ff <= 1'b0;
         running_thread <= '0;
         running_idle <= 1'b0;
         switched <= 1'b0;
         preempted <= 1'b0;
         new_thread <= '0;
         status <= RS_OK;
      end else begin
         if (cmd.start) begin
            op_ff <= op_code;
            prio_ff <= prio_in;
            prev_cur_ff <= cur_ff;
            prev_idle_ff <= idle_ff;
            free_ff <= free_idx;
            free_ok_ff <= free_found;
            disp_ff <= 1'b0;
            pre_ff <= 1'b0;
            newt_ff <= '0;
            stat_ff <= RS_OK;
         end
         if (cmd.execute) begin
            unique case (op_ff)
               OP_CREATE: begin
                  if (!free_ok_ff) stat_ff <= RS_NOFREE;
                  else begin
                     slot_prio_ff[free_ff] <= prio_ff;
                     slot_tick_ff[free_ff] <= quantum_len;
                     slot_st_ff[free_ff] <= ST_READY;
                     newt_ff <= free_ff;
                     q = prio_ff ? 2'd0 : 2'd1;
                     if (idle_ff) begin
                        // queue empty while idle: the new thread is queued and then dispatched in this event
                        q_mem_ff[q][tail_of(head_ff[q], cnt_ff[q])] <= free_ff;
                        cnt_ff[q] <= cnt_ff[q] + 1'b1;
                        disp_ff <= 1'b1;
                     end else if (!slot_prio_ff[cur_ff] && prio_ff) begin
                        // high queue gets new, low queue gets preempted current
                        q_mem_ff[0][tail_of(head_ff[0], cnt_ff[0])] <= free_ff;
                        cnt_ff[0] <= cnt_ff[0] + 1'b1;
                        q_mem_ff[1][tail_of(head_ff[1], cnt_ff[1])] <= cur_ff;
                        cnt_ff[1] <= cnt_ff[1] + 1'b1;
                        slot_st_ff[cur_ff] <= ST_READY;
                        disp_ff <= 1'b1;
                        pre_ff <= 1'b1;
                     end else begin
                        q_mem_ff[q][tail_of(head_ff[q], cnt_ff[q])] <= free_ff;
                        cnt_ff[q] <= cnt_ff[q] + 1'b1;
                     end
                  end
               end
               OP_TICK: begin
                  if (idle_ff) stat_ff <= RS_IDLE;
                  else begin
                     t = slot_tick_ff[cur_ff];
                     if (t != 8'd0) t = t - 8'd1;
                     if (!slot_prio_ff[cur_ff] && t == 8'd0) begin
                        slot_tick_ff[cur_ff] <= quantum_len;
                        slot_st_ff[cur_ff] <= ST_READY;
                        q_mem_ff[1][tail_of(head_ff[1], cnt_ff[1])] <= cur_ff;
                        cnt_ff[1] <= cnt_ff[1] + 1'b1;
                        disp_ff <= 1'b1;
                     end else slot_tick_ff[cur_ff] <= t;
                  end
               end
               OP_BLOCK: begin
                  if (idle_ff) stat_ff <= RS_IDLE;
                  else begin
                     slot_st_ff[cur_ff] <= ST_WAITING;
                     if (cnt_ff[2] != FULL) begin
                        q_mem_ff[2][tail_of(head_ff[2], cnt_ff[2])] <= cur_ff;
                        cnt_ff[2] <= cnt_ff[2] + 1'b1;
                     end
                     disp_ff <= 1'b1;
                  end
               end
               OP_NETRDY: begin
                  if (cnt_ff[2] == '0) stat_ff <= RS_NOWAIT;
                  else begin
                     v = q_mem_ff[2][head_ff[2]];
                     newt_ff <= v;
                     head_ff[2] <= head_ff[2] + 1'b1;
                     cnt_ff[2] <= cnt_ff[2] - 1'b1;
                     slot_st_ff[v] <= ST_READY;
                     q = slot_prio_ff[v] ? 2'd0 : 2'd1;
                     if (idle_ff) begin
                        q_mem_ff[q][tail_of(head_ff[q], cnt_ff[q])] <= v;
                        cnt_ff[q] <= cnt_ff[q] + 1'b1;
                        disp_ff <= 1'b1;
                     end else if (!slot_prio_ff[cur_ff] && slot_tick_ff[cur_ff] == 8'd0)
                     begin
                        // woken thread to the tail of its queue, current to the low queue tail (behind it if both low)
                        slot_tick_ff[cur_ff] <= quantum_len;
                        slot_st_ff[cur_ff] <= ST_READY;
                        if (q == 2'd0) begin
                           q_mem_ff[0][tail_of(head_ff[0], cnt_ff[0])] <= v;
                           cnt_ff[0] <= cnt_ff[0] + 1'b1;
                           q_mem_ff[1][tail_of(head_ff[1], cnt_ff[1])] <= cur_ff;
                           cnt_ff[1] <= cnt_ff[1] + 1'b1;
                        end else begin
                           q_mem_ff[1][tail_of(head_ff[1], cnt_ff[1])] <= v;
                           q_mem_ff[1][tail_of(head_ff[1], cnt_ff[1] + 1'b1)] <= cur_ff;
                           cnt_ff[1] <= cnt_ff[1] + 2'd2;
                        end
                        disp_ff <= 1'b1;
                     end else begin
                        q_mem_ff[q][tail_of(head_ff[q], cnt_ff[q])] <= v;
                        cnt_ff[q] <= cnt_ff[q] + 1'b1;
                     end
                  end
               end
               OP_EXIT: begin
                  if (idle_ff) stat_ff <= RS_IDLE;
                  else begin
                     slot_st_ff[cur_ff] <= ST_FREE;
                     disp_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.dispatch && disp_ff) begin
            if (cnt_ff[0] != '0) begin
               v = q_mem_ff[0][head_ff[0]];
               head_ff[0] <= head_ff[0] + 1'b1;
               cnt_ff[0] <= cnt_ff[0] - 1'b1;
               cur_ff <= v;
               slot_st_ff[v] <= ST_RUNNING;
               idle_ff <= 1'b0;
            end else if (cnt_ff[1] != '0) begin
               v = q_mem_ff[1][head_ff[1]];
               head_ff[1] <= head_ff[1] + 1'b1;
               cnt_ff[1] <= cnt_ff[1] - 1'b1;
               cur_ff <= v;
               slot_st_ff[v] <= ST_RUNNING;
               idle_ff <= 1'b0;
            end else idle_ff <= 1'b1;
         end
         if (cmd.finish) begin
            running_thread <= idle_ff ? 4'd0 : 4'(cur_ff);
            running_idle <= idle_ff;
            switched <= (idle_ff != prev_idle_ff) || (!idle_ff && cur_ff != prev_cur_ff);
            preempted <= pre_ff;
            new_thread <= 4'(newt_ff);
            status <= stat_ff;
         end
      end
   end
endmodule

// ===== rtl/tlts_ctrl.sv =====
// Controller of the thread scheduler: sequences one event through its phases
// and runs the result handshake. Depends on tlts_pkg.
module tlts_ctrl
   import tlts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_DISP = 5'b00100,
      S_FIN  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.start = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in = S_DISP;
         end
         S_DISP: begin
            cmd.dispatch = stat.need_dispatch;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== rtl/two_level_thread_scheduler.sv =====
// Two-level thread scheduler. Each event (create, timer tick, block, network
// ready, exit) passes through the controller sequence start/apply/dispatch/report
// over the registered slot and queue updates; a new event is taken only after
// the result of the last one has been taken.
// The quantum register resets to 10. Depends on tlts_pkg, tlts_ctrl, tlts_datapath.
module two_level_thread_scheduler
   import tlts_pkg::*;
#(
   parameter int THREAD_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic       req_priority_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_running_thread,
   output logic       rsp_running_idle,
   output logic       rsp_switched,
   output logic       rsp_preempted,
   output logic [3:0] rsp_new_thread,
   output logic [1:0] rsp_status,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   logic [7:0]    quantum_ff;
   dp_cmd_type    cmd;
   dp_status_type stat;

   always_ff @(posedge clock) begin
      if (reset) quantum_ff <= 8'd10;
      else if (csr_write_enable) quantum_ff <= csr_write_data;
   end

   tlts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   tlts_datapath #(.THREAD_SLOTS(THREAD_SLOTS)) u_dp (
      .clock, .reset,
      .quantum_len   (quantum_ff),
      .op_code       (req_operation),
      .prio_in       (req_priority_req),
      .cmd, .stat,
      .running_thread(rsp_running_thread),
      .running_idle  (rsp_running_idle),
      .switched      (rsp_switched),
      .preempted     (rsp_preempted),
      .new_thread    (rsp_new_thread),
      .status        (rsp_status)
   );
endmodule

// ===== rtl/tlts_checker.sv =====
// Port-level checker for the thread scheduler, bound to the top level.
// Depends on tlts_pkg for status codes.
module tlts_checker
   import tlts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_running_idle,
   input logic [3:0] rsp_running_thread,
   input logic       rsp_preempted,
   input logic [1:0] rsp_status
);
   // one event in flight: no new transfer while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer right after an accepted event");
   a_idle_thread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running_idle |-> rsp_running_thread == 4'd0)
      else $error("thread number nonzero while idle");
   a_preempt_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_preempted |-> rsp_status == RS_OK && !rsp_running_idle)
      else $error("preemption with error status");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");
endmodule

bind two_level_thread_scheduler tlts_checker u_tlts_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_running_idle, .rsp_running_thread, .rsp_preempted, .rsp_status
);
